// ===== rtl/impq_pkg.sv =====
`timescale 1ns / 1ps

package impq_pkg;

    localparam int KEY_W        = 8;
    localparam int PRIO_W       = 32;
    localparam int CNT_W        = 9;
    localparam int STAT_W       = 2;
    localparam int KEY_SPACE    = 256;
    localparam int CAPACITY_DEF = 256;

    localparam logic CMD_POP    = 1'b0;
    localparam logic CMD_UPSERT = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_POP,
        S_UP,
        S_UPC,
        S_DN,
        S_DNC,
        S_FIN
    } state_t;

    // strict signed less-than on raw priority bits
    function automatic logic prio_less(input logic [PRIO_W-1:0] a,
                                       input logic [PRIO_W-1:0] b);
        prio_less = $signed(a) < $signed(b);
    endfunction

endpackage

// ===== rtl/impq_if.sv =====
`timescale 1ns / 1ps

interface impq_in_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [impq_pkg::KEY_W-1:0]       key;
    logic signed [impq_pkg::PRIO_W-1:0] priority_req;

    modport source (output valid, command, key, priority_req, input ready);
    modport sink (input valid, command, key, priority_req, output ready);
endinterface

interface impq_out_if;
    logic                               valid;
    logic                               ready;
    logic [impq_pkg::KEY_W-1:0]         out_key;
    logic signed [impq_pkg::PRIO_W-1:0] out_priority;
    logic [impq_pkg::STAT_W-1:0]        status;
    logic [impq_pkg::CNT_W-1:0]         count;

    modport source (output valid, out_key, out_priority, status, count, input ready);
    modport sink (input valid, out_key, out_priority, status, count, output ready);
endinterface

// ===== rtl/impq_heap_ram.sv =====
`timescale 1ns / 1ps

// heap entry storage: one write port, two registered read ports
module impq_heap_ram #(
    parameter int DEPTH = impq_pkg::CAPACITY_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  impq_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_a_addr,
    input  logic [AW-1:0]        rd_b_addr,
    output impq_pkg::entry_t     rd_a_data,
    output impq_pkg::entry_t     rd_b_data
);

    impq_pkg::entry_t mem [DEPTH];
    impq_pkg::entry_t rd_a_reg;
    impq_pkg::entry_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

// ===== rtl/indexed_max_priority_queue_core.sv =====
`timescale 1ns / 1ps
// Command paths: an empty pop goes straight to the result, a refused insert after a key lookup;
//   a pop sinks the last entry from the root, an insert rises from a new leaf, an update rises
//   then sinks from its present position; each sift pass ends at the root, a leaf or a compare.
// Throughput: one command at a time, each level one heap RAM read then one compare/write;
//   the result waits in an output register while the core returns to idle for the next command.
// Reset (rst_n, async low) empties the queue: count and key-present bits clear; RAMs keep data.
module indexed_max_priority_queue_core #(
    parameter int CAPACITY = impq_pkg::CAPACITY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    impq_in_if.sink          req,
    impq_out_if.source       rsp
);

    // only 256 distinct keys exist, so storage never needs more
    localparam int EFF = (CAPACITY < impq_pkg::KEY_SPACE) ? CAPACITY : impq_pkg::KEY_SPACE;
    localparam int PW  = $clog2(EFF + 1);
    localparam int WW  = impq_pkg::CNT_W + 1;

    impq_pkg::state_t state_reg, state_next;

    logic [impq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [PW-1:0]               hole_reg, hole_next;
    impq_pkg::entry_t            cur_reg, cur_next;      // entry being sifted
    impq_pkg::entry_t            wres_reg, wres_next;    // popped entry
    logic [impq_pkg::STAT_W-1:0] wstat_reg, wstat_next;
    logic                        down_reg, down_next;    // sift down after sift up
    logic                        fwr_reg, fwr_next;      // place cur at hole on finish

    logic                        rsp_valid_reg, rsp_valid_next;
    impq_pkg::entry_t            rsp_ent_reg, rsp_ent_next;
    logic [impq_pkg::STAT_W-1:0] rsp_stat_reg, rsp_stat_next;
    logic [impq_pkg::CNT_W-1:0]  rsp_cnt_reg, rsp_cnt_next;

    logic [impq_pkg::KEY_SPACE-1:0] valid_reg, valid_next;

    // position map RAM
    logic [PW-1:0]              pmap_mem [impq_pkg::KEY_SPACE];
    logic [PW-1:0]              pmap_rd_reg;
    logic                       pmap_wr_en;
    logic [impq_pkg::KEY_W-1:0] pmap_wr_key;
    logic [PW-1:0]              pmap_wr_pos;

    // heap RAM controls
    logic             heap_wr_en;
    logic [PW-1:0]    heap_wr_addr;
    impq_pkg::entry_t heap_wr_data;
    logic             heap_rd_en;
    logic [PW-1:0]    heap_rd_a;
    logic [PW-1:0]    heap_rd_b;
    impq_pkg::entry_t rd_a;
    impq_pkg::entry_t rd_b;

    logic             req_xfer;
    logic             fin_go;
    logic [WW-1:0]    dbl;
    logic [WW-1:0]    cnt_ext;
    logic             dn_go;
    logic             dn_has_b;
    logic             dn_selb;
    impq_pkg::entry_t dn_child;
    logic [PW-1:0]    dn_pos;
    logic             dn_move;
    logic             up_move;
    logic             hit;

    impq_heap_ram #(
        .DEPTH (EFF + 1),
        .AW    (PW)
    ) u_heap (
        .clk       (clk),
        .wr_en     (heap_wr_en),
        .wr_addr   (heap_wr_addr),
        .wr_data   (heap_wr_data),
        .rd_en     (heap_rd_en),
        .rd_a_addr (heap_rd_a),
        .rd_b_addr (heap_rd_b),
        .rd_a_data (rd_a),
        .rd_b_data (rd_b)
    );

    assign req.ready = (state_reg == impq_pkg::S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign fin_go    = !rsp_valid_reg || rsp.ready;

    // child index math, widened so 2*hole cannot wrap
    assign dbl      = WW'(hole_reg) << 1;
    assign cnt_ext  = WW'(count_reg);
    assign dn_go    = dbl <= cnt_ext;
    assign dn_has_b = dbl < cnt_ext;
    assign dn_selb  = dn_has_b && impq_pkg::prio_less(rd_a.prio, rd_b.prio);
    assign dn_child = dn_selb ? rd_b : rd_a;
    assign dn_pos   = dbl[PW-1:0] + PW'(dn_selb);
    assign dn_move  = impq_pkg::prio_less(cur_reg.prio, dn_child.prio);
    assign up_move  = impq_pkg::prio_less(rd_a.prio, cur_reg.prio);
    assign hit      = valid_reg[cur_reg.key];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            impq_pkg::S_IDLE:
            begin
                if (req_xfer)
                begin
                    if (req.command == impq_pkg::CMD_UPSERT)
                    begin
                        state_next = impq_pkg::S_LOOK;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = impq_pkg::S_FIN;
                    end
                    else
                    begin
                        state_next = impq_pkg::S_POP;
                    end
                end
            end
            impq_pkg::S_LOOK:
            begin
                if (!hit && (count_reg >= impq_pkg::CNT_W'(EFF)))
                begin
                    state_next = impq_pkg::S_FIN;
                end
                else
                begin
                    state_next = impq_pkg::S_UP;
                end
            end
            impq_pkg::S_POP:
            begin
                state_next = impq_pkg::S_DN;
            end
            impq_pkg::S_UP:
            begin
                if (hole_reg > PW'(1))
                begin
                    state_next = impq_pkg::S_UPC;
                end
                else
                begin
                    state_next = down_reg ? impq_pkg::S_DN : impq_pkg::S_FIN;
                end
            end
            impq_pkg::S_UPC:
            begin
                if (up_move)
                begin
                    state_next = impq_pkg::S_UP;
                end
                else
                begin
                    state_next = down_reg ? impq_pkg::S_DN : impq_pkg::S_FIN;
                end
            end
            impq_pkg::S_DN:
            begin
                state_next = dn_go ? impq_pkg::S_DNC : impq_pkg::S_FIN;
            end
            impq_pkg::S_DNC:
            begin
                state_next = dn_move ? impq_pkg::S_DN : impq_pkg::S_FIN;
            end
            impq_pkg::S_FIN:
            begin
                if (fin_go)
                begin
                    state_next = impq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = impq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and RAM controls
    always_comb
    begin
        count_next     = count_reg;
        hole_next      = hole_reg;
        cur_next       = cur_reg;
        wres_next      = wres_reg;
        wstat_next     = wstat_reg;
        down_next      = down_reg;
        fwr_next       = fwr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_ent_next   = rsp_ent_reg;
        rsp_stat_next  = rsp_stat_reg;
        rsp_cnt_next   = rsp_cnt_reg;
        valid_next     = valid_reg;
        heap_wr_en     = 1'b0;
        heap_wr_addr   = hole_reg;
        heap_wr_data   = cur_reg;
        heap_rd_en     = 1'b0;
        heap_rd_a      = hole_reg >> 1;
        heap_rd_b      = hole_reg;
        pmap_wr_en     = 1'b0;
        pmap_wr_key    = cur_reg.key;
        pmap_wr_pos    = hole_reg;

        if (rsp.valid && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            impq_pkg::S_IDLE:
            begin
                if (req_xfer)
                begin
                    cur_next   = '{key: req.key, prio: req.priority_req};
                    wres_next  = '0;
                    wstat_next = impq_pkg::ST_OK;
                    fwr_next   = 1'b0;
                    if (req.command == impq_pkg::CMD_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            wstat_next = impq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            heap_rd_en = 1'b1;
                            heap_rd_a  = PW'(1);
                            heap_rd_b  = count_reg[PW-1:0];
                        end
                    end
                end
            end
            impq_pkg::S_LOOK:
            begin
                if (hit)
                begin
                    hole_next = pmap_rd_reg;
                    down_next = 1'b1;
                    fwr_next  = 1'b1;
                end
                else if (count_reg >= impq_pkg::CNT_W'(EFF))
                begin
                    wstat_next = impq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + impq_pkg::CNT_W'(1);
                    hole_next  = count_reg[PW-1:0] + PW'(1);
                    down_next  = 1'b0;
                    fwr_next   = 1'b1;
                end
            end
            impq_pkg::S_POP:
            begin
                // last entry moves into the root hole and sinks
                wres_next             = rd_a;
                cur_next              = rd_b;
                valid_next[rd_a.key]  = 1'b0;
                count_next            = count_reg - impq_pkg::CNT_W'(1);
                hole_next             = PW'(1);
                down_next             = 1'b1;
                fwr_next              = (count_reg != impq_pkg::CNT_W'(1));
            end
            impq_pkg::S_UP:
            begin
                if (hole_reg > PW'(1))
                begin
                    heap_rd_en = 1'b1;
                end
            end
            impq_pkg::S_UPC:
            begin
                if (up_move)
                begin
                    heap_wr_en             = 1'b1;
                    heap_wr_data           = rd_a;
                    pmap_wr_en             = 1'b1;
                    pmap_wr_key            = rd_a.key;
                    valid_next[rd_a.key]   = 1'b1;
                    hole_next              = hole_reg >> 1;
                end
            end
            impq_pkg::S_DN:
            begin
                if (dn_go)
                begin
                    heap_rd_en = 1'b1;
                    heap_rd_a  = dbl[PW-1:0];
                    heap_rd_b  = dn_has_b ? (dbl[PW-1:0] + PW'(1)) : dbl[PW-1:0];
                end
            end
            impq_pkg::S_DNC:
            begin
                if (dn_move)
                begin
                    heap_wr_en               = 1'b1;
                    heap_wr_data             = dn_child;
                    pmap_wr_en               = 1'b1;
                    pmap_wr_key              = dn_child.key;
                    valid_next[dn_child.key] = 1'b1;
                    hole_next                = dn_pos;
                end
            end
            impq_pkg::S_FIN:
            begin
                if (fin_go)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ent_next   = wres_reg;
                    rsp_stat_next  = wstat_reg;
                    rsp_cnt_next   = count_reg;
                    if (fwr_reg)
                    begin
                        heap_wr_en             = 1'b1;
                        pmap_wr_en             = 1'b1;
                        valid_next[cur_reg.key] = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= impq_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg     <= hole_next;
        cur_reg      <= cur_next;
        wres_reg     <= wres_next;
        wstat_reg    <= wstat_next;
        down_reg     <= down_next;
        fwr_reg      <= fwr_next;
        rsp_ent_reg  <= rsp_ent_next;
        rsp_stat_reg <= rsp_stat_next;
        rsp_cnt_reg  <= rsp_cnt_next;
    end

    // position map RAM
    always_ff @(posedge clk)
    begin
        if (pmap_wr_en)
        begin
            pmap_mem[pmap_wr_key] <= pmap_wr_pos;
        end
        if (req_xfer)
        begin
            pmap_rd_reg <= pmap_mem[req.key];
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.out_key      = rsp_ent_reg.key;
    assign rsp.out_priority = rsp_ent_reg.prio;
    assign rsp.status       = rsp_stat_reg;
    assign rsp.count        = rsp_cnt_reg;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= impq_pkg::CNT_W'(EFF))
        else $error("entry count above capacity");

    a_hole_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == impq_pkg::S_UP || state_reg == impq_pkg::S_DN ||
         state_reg == impq_pkg::S_UPC || state_reg == impq_pkg::S_DNC) |-> hole_reg != '0)
        else $error("sift hole at position zero");

    a_fin_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == impq_pkg::S_FIN && fwr_reg) |-> WW'(hole_reg) <= cnt_ext)
        else $error("final placement outside heap");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stat_reg == impq_pkg::ST_EMPTY) |-> rsp_cnt_reg == '0)
        else $error("empty status with nonzero count");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == impq_pkg::S_POP |=> count_reg == $past(count_reg) - impq_pkg::CNT_W'(1))
        else $error("pop did not shrink count");
`endif

endmodule
